/* hw/rtl/nhlc_pkg.sv */
// Shared types, constants and the header name table for the header line classifier.
`default_nettype none

package nhlc_pkg;

    localparam int NAME_COUNT    = 28;
    localparam int MAX_NAME_LEN  = 16;
    localparam int TABLE_LEN     = 28;
    localparam int NAME_TEXT_LEN = 16;
    localparam int POS_W = $clog2(((MAX_NAME_LEN > NAME_TEXT_LEN) ?
                                   MAX_NAME_LEN : NAME_TEXT_LEN) + 1);
    localparam int KIND_W = 5;

    localparam logic [KIND_W-1:0] KIND_NONE  = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_OTHER = KIND_W'(27);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_ASCII_MAX = 8'h7F;

    typedef enum logic [1:0] {
        LM_START   = 2'd0,
        LM_HEADER  = 2'd1,
        LM_DECIDED = 2'd2
    } line_mode_t;

    // Broadcast from the control section to every cell
    typedef struct packed {
        logic             take;
        logic             clear;
        logic [7:0]       lc;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] pos_after;
    } cell_ctl_t;

    // One table entry as seen by a cell at the current position
    typedef struct packed {
        logic              present;
        logic [7:0]        ch;
        logic [POS_W-1:0]  len;
        logic [KIND_W-1:0] kind;
    } name_ent_t;

    // Priority chain passed from cell to cell
    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } chain_t;

    // Lowercase names, right-justified in the literal
    localparam logic [8*NAME_TEXT_LEN-1:0] NAME_TEXT [TABLE_LEN] = '{
        "approved:", "article-i.d.:", "control:", "date-received:", "date:",
        "distribution:", "expires:", "followup-to:", "from:", "in-reply-to:",
        "keywords:", "lines:", "message-id:", "newsgroups:", "nf-from:",
        "nf-id:", "organization:", "path:", "posted:", "posting-version:",
        "references:", "relay-version:", "reply-to:", "sender:", "subject:",
        "summary:", "title:", "xref:"
    };

    localparam int NAME_LEN_TAB [TABLE_LEN] = '{
        9, 13, 8, 14, 5, 13, 8, 12, 5, 12, 9, 6, 11, 11, 8,
        6, 13, 5, 7, 16, 11, 14, 9, 7, 8, 8, 6, 5
    };

    localparam int NAME_KIND_TAB [TABLE_LEN] = '{
        21, 7, 11, 5, 4, 17, 6, 13, 1, 10, 20, 19, 8, 2, 23,
        22, 18, 14, 4, 15, 10, 16, 9, 12, 3, 25, 3, 24
    };

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UC_A && c <= CH_UC_Z) begin
            r = c + CH_CASE;
        end
        return r;
    endfunction

    function automatic name_ent_t name_entry(input int idx, input logic [POS_W-1:0] pos);
        name_ent_t                  e;
        logic [8*NAME_TEXT_LEN-1:0] txt;
        e   = '0;
        txt = '0;
        if (idx < TABLE_LEN) begin
            // left-justify so that byte k sits at a fixed place
            txt = NAME_TEXT[idx] << (8 * (NAME_TEXT_LEN - NAME_LEN_TAB[idx]));
            e.present = 1'b1;
            e.len     = POS_W'(NAME_LEN_TAB[idx]);
            e.kind    = KIND_W'(NAME_KIND_TAB[idx]);
            for (int k = 0; k < NAME_TEXT_LEN; k++) begin
                if (pos == POS_W'(k)) begin
                    e.ch = txt[8*(NAME_TEXT_LEN-1-k) +: 8];
                end
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/news_header_line_classifier_unit.sv */
// Top level of the header line classifier: line control, cell row and result register.
//
// Input channel (item_valid / item_stall): one byte ch per transfer, with
// line_end on the last byte of a line, or no_line to mark end of input.
// Result channel (result_valid / result_stall): header_kind, one transfer per
// line end and per no_line item; other bytes give no result.
// A row of NAME_COUNT cells, one per header name, compares every byte of a header line against
// all names in the same cycle; the first-match choice ripples along the row.
// The result is registered and shows in the cycle after the line end byte
// is taken. Throughput: one byte per cycle while the receiver does not stall,
// set by the single compare stage in each cell.
// Reset clears line state and the remembered kind; the next byte starts a new
// line. While the receiver stalls with a result waiting, item_stall is high
// and the result holds; otherwise the block takes a byte every cycle.
`default_nettype none

module news_header_line_classifier_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [7:0]                    ch,
    input  logic                          line_end,
    input  logic                          no_line,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [nhlc_pkg::KIND_W-1:0]   header_kind
);
    import nhlc_pkg::*;

    line_mode_t        mode_reg, mode_next, mode_eff;
    logic [POS_W-1:0]  pos_reg, pos_next, pos_after;
    logic [KIND_W-1:0] found_reg, found_next, found_eff;
    logic [KIND_W-1:0] last_reg, last_next;
    logic              colon_reg, colon_next, colon_eff;
    logic              space_reg, space_next, space_eff;
    logic              rvalid_reg, rvalid_next;
    logic [KIND_W-1:0] rkind_reg, rkind_next;

    logic              fire;
    logic              take;
    logic              clear;
    logic              emit;
    logic [KIND_W-1:0] decide_kind;
    logic [KIND_W-1:0] kind_res;

    cell_ctl_t         ctl;
    chain_t            chain [NAME_COUNT+1];

    assign item_stall   = rvalid_reg && result_stall;
    assign fire         = item_valid && !item_stall;
    assign result_valid = rvalid_reg;
    assign header_kind  = rkind_reg;

    // Line front end: classify the first byte, track colon and position
    always_comb
    begin
        mode_eff  = mode_reg;
        found_eff = found_reg;
        take      = 1'b0;
        if (fire && !no_line) begin
            unique case (mode_reg)
                LM_START:
                begin
                    priority if (ch > CH_ASCII_MAX || ch == CH_NL) begin
                        found_eff = KIND_NONE;
                        mode_eff  = LM_DECIDED;
                    end else if (ch == CH_SPACE || ch == CH_TAB) begin
                        found_eff = last_reg;
                        mode_eff  = LM_DECIDED;
                    end else begin
                        mode_eff  = LM_HEADER;
                        take      = 1'b1;
                    end
                end
                LM_HEADER:
                begin
                    take = 1'b1;
                end
                default:
                begin
                    take = 1'b0;
                end
            endcase
        end

        colon_eff = colon_reg;
        space_eff = space_reg;
        pos_after = pos_reg;
        if (take) begin
            if (!colon_reg) begin
                if (ch == CH_SPACE) begin
                    space_eff = 1'b1;
                end else if (ch == CH_COLON) begin
                    colon_eff = 1'b1;
                end
            end
            if (pos_reg < POS_W'(MAX_NAME_LEN)) begin
                pos_after = pos_reg + POS_W'(1);
            end
        end

        clear = fire && (no_line || line_end);

        ctl.take      = take;
        ctl.clear     = clear;
        ctl.lc        = lower_byte(ch);
        ctl.pos       = pos_reg;
        ctl.pos_after = pos_after;
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < NAME_COUNT; i++) begin : g_cell
        nhlc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .name      (name_entry(i, pos_reg)),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // Line decision and next state
    always_comb
    begin
        if (!colon_eff || space_eff) begin
            decide_kind = KIND_NONE;
        end else if (chain[NAME_COUNT].hit) begin
            decide_kind = chain[NAME_COUNT].kind;
        end else begin
            decide_kind = KIND_OTHER;
        end

        emit      = 1'b0;
        kind_res  = KIND_NONE;
        last_next = last_reg;
        if (fire) begin
            if (no_line) begin
                emit      = 1'b1;
                last_next = KIND_NONE;
            end else if (line_end) begin
                emit      = 1'b1;
                kind_res  = (mode_eff == LM_HEADER) ? decide_kind : found_eff;
                last_next = kind_res;
            end
        end

        if (clear) begin
            mode_next  = LM_START;
            found_next = KIND_NONE;
            colon_next = 1'b0;
            space_next = 1'b0;
            pos_next   = '0;
        end else begin
            mode_next  = mode_eff;
            found_next = found_eff;
            colon_next = colon_eff;
            space_next = space_eff;
            pos_next   = pos_after;
        end

        // hold a waiting result until the receiver takes it
        rvalid_next = rvalid_reg;
        rkind_next  = rkind_reg;
        if (emit) begin
            rvalid_next = 1'b1;
            rkind_next  = kind_res;
        end else if (!result_stall) begin
            rvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= LM_START;
            pos_reg    <= '0;
            found_reg  <= KIND_NONE;
            last_reg   <= KIND_NONE;
            colon_reg  <= 1'b0;
            space_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            found_reg  <= found_next;
            last_reg   <= last_next;
            colon_reg  <= colon_next;
            space_reg  <= space_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rkind_reg <= rkind_next;
    end

    a_no_line_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && no_line |=> result_valid && header_kind == KIND_NONE && last_reg == KIND_NONE)
        else $error("end of input did not give a zero result");

    a_line_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && line_end |=> result_valid && mode_reg == LM_START && pos_reg == '0)
        else $error("line end did not give a result and restart the line");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> header_kind <= KIND_OTHER)
        else $error("header kind out of range");

    a_mid_line_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !line_end && !no_line && !item_stall |=> !result_valid || $past(rvalid_reg))
        else $error("result without a line end");

endmodule

`default_nettype wire

/* hw/rtl/nhlc_cell.sv */
// One match cell: tracks a single header name and joins the first-match priority chain.
`default_nettype none

module nhlc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  nhlc_pkg::cell_ctl_t ctl,
    input  nhlc_pkg::name_ent_t name,
    input  nhlc_pkg::chain_t    chain_in,
    output nhlc_pkg::chain_t    chain_out
);
    import nhlc_pkg::*;

    logic match_reg;
    logic match_next;
    logic match_eff;
    logic hit;

    always_comb
    begin
        match_eff = match_reg;
        if (ctl.take && (ctl.pos < name.len) && (name.ch != ctl.lc)) begin
            match_eff = 1'b0;
        end
        match_next = ctl.clear ? 1'b1 : match_eff;
        hit = name.present && match_eff && (ctl.pos_after >= name.len);

        // earlier table entries win
        chain_out = chain_in;
        if (!chain_in.hit && hit) begin
            chain_out.hit  = 1'b1;
            chain_out.kind = name.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            match_reg <= 1'b1;
        end else begin
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the news header line classifier unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nhlc_pkg::*;

    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 900;
    localparam int CALM_ITEMS     = 150;
    localparam int HOLD_AT_ITEM   = 400;
    localparam int PAUSE_AT_ITEM  = 700;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 5;
    localparam int KIND_BY_TABLE  = -1;

    localparam logic [KIND_W-1:0] KIND_FROM        = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_DATE        = KIND_W'(4);
    localparam logic [KIND_W-1:0] KIND_DATE_RCVD   = KIND_W'(5);
    localparam logic [KIND_W-1:0] KIND_POSTING_VER = KIND_W'(15);

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    logic [7:0]        ch;
    logic              line_end;
    logic              no_line;
    logic              result_valid;
    logic              result_stall;
    logic [KIND_W-1:0] header_kind;

    news_header_line_classifier_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .ch           (ch),
        .line_end     (line_end),
        .no_line      (no_line),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .header_kind  (header_kind)
    );

    // Header names in table order; the first full match wins
    string hdr_name [TABLE_LEN] = '{
        "Approved:", "Article-I.D.:", "Control:", "Date-Received:", "Date:",
        "Distribution:", "Expires:", "Followup-To:", "From:", "In-Reply-To:",
        "Keywords:", "Lines:", "Message-ID:", "Newsgroups:", "Nf-From:",
        "Nf-ID:", "Organization:", "Path:", "Posted:", "Posting-Version:",
        "References:", "Relay-Version:", "Reply-To:", "Sender:", "Subject:",
        "Summary:", "Title:", "Xref:"
    };
    int hdr_kind [TABLE_LEN] = '{
        21, 7, 11, 5, 4, 17, 6, 13, 1, 10, 20, 19, 8, 2, 23,
        22, 18, 14, 4, 15, 10, 16, 9, 12, 3, 25, 3, 24
    };

    // Predictor state
    logic [NAME_COUNT-1:0] alive;
    logic [4:0]            col;
    logic [KIND_W-1:0]     held_kind;
    logic                  got_colon;
    logic                  blank_first;
    line_mode_t            mode;
    logic [KIND_W-1:0]     prev_kind;

    logic [KIND_W-1:0] pending_kinds [$];
    logic [7:0]        line_bytes [$];
    int                mismatch_count;
    int                sent_count;
    bit                idle_en;
    bit                hold_off_go;

    typedef struct {
        string      text;
        logic [7:0] lead;
        bit         has_lead;
        bit         open_end;
        bit         end_of_input;
        int         kind;
    } line_case_t;

    line_case_t dir_cases [27] = '{
        '{"",                      8'h00, 0, 0, 1, int'(KIND_NONE)},
        '{"From: someone",         8'h00, 0, 0, 0, int'(KIND_FROM)},
        '{" wrapped",              8'h00, 0, 0, 0, int'(KIND_FROM)},
        '{"\tmore",                8'h00, 0, 0, 0, int'(KIND_FROM)},
        '{"",                      CH_NL, 1, 0, 0, int'(KIND_NONE)},
        '{" after empty",          8'h00, 0, 0, 0, int'(KIND_NONE)},
        '{"DATE-RECEIVED: today",  8'h00, 0, 0, 0, int'(KIND_DATE_RCVD)},
        '{"date:x",                8'h00, 0, 0, 0, int'(KIND_DATE)},
        '{"X-Mailer: y",           8'h00, 0, 0, 0, int'(KIND_OTHER)},
        '{" cont other",           8'h00, 0, 0, 0, int'(KIND_OTHER)},
        '{"Sub ject: z",           8'h00, 0, 0, 0, int'(KIND_NONE)},
        '{"no colon here",         8'h00, 0, 0, 0, int'(KIND_NONE)},
        '{"Posting-Version: 1",    8'h00, 0, 0, 0, int'(KIND_POSTING_VER)},
        '{"Fro:",                  8'h00, 0, 0, 0, int'(KIND_OTHER)},
        '{"From: x",               8'h80, 1, 0, 0, int'(KIND_NONE)},
        '{" after high byte",      8'h00, 0, 0, 0, int'(KIND_NONE)},
        '{"",                      8'hFF, 1, 0, 0, int'(KIND_NONE)},
        '{":",                     8'h7F, 1, 0, 0, int'(KIND_OTHER)},
        '{"Fro",                   8'h00, 0, 1, 0, KIND_BY_TABLE},
        '{"",                      8'h00, 0, 0, 1, int'(KIND_NONE)},
        '{"m: x",                  8'h00, 0, 0, 0, int'(KIND_OTHER)},
        '{"Lines:\nmore",          8'h00, 0, 0, 0, KIND_BY_TABLE},
        '{"Reply-To: a",           8'h00, 0, 0, 0, KIND_BY_TABLE},
        '{"Nf-ID: b",              8'h00, 0, 0, 0, KIND_BY_TABLE},
        '{"Q",                     8'h00, 0, 0, 0, KIND_BY_TABLE},
        '{" ",                     8'h00, 0, 0, 0, KIND_BY_TABLE},
        '{"SuBjEcT:t",             8'h00, 0, 0, 0, KIND_BY_TABLE}
    };

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c + 8'h20;
        return c;
    endfunction

    function automatic void restart_line();
        alive       = '1;
        col         = '0;
        held_kind   = KIND_NONE;
        got_colon   = 1'b0;
        blank_first = 1'b0;
        mode        = LM_START;
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic [7:0] want;
        if (!got_colon)
        begin
            if (c == CH_SPACE)
                blank_first = 1'b1;
            else if (c == CH_COLON)
                got_colon = 1'b1;
        end
        for (int i = 0; i < NAME_COUNT && i < TABLE_LEN; i++)
        begin
            if (alive[i] && col < hdr_name[i].len())
            begin
                want = hdr_name[i][col];
                if (fold_case(want) != fold_case(c))
                    alive[i] = 1'b0;
            end
        end
        if (col < MAX_NAME_LEN)
            col = col + 1'b1;
    endfunction

    function automatic logic [KIND_W-1:0] decide_kind();
        if (!got_colon || blank_first)
            return KIND_NONE;
        for (int i = 0; i < NAME_COUNT && i < TABLE_LEN; i++)
        begin
            if (alive[i] && col >= hdr_name[i].len())
                return KIND_W'(hdr_kind[i]);
        end
        return KIND_OTHER;
    endfunction

    // Advance the predictor by one transfer; return 1 when a result is due
    function automatic logic classify_byte(input logic [7:0] c, input logic e,
                                           input logic n, output logic [KIND_W-1:0] kind);
        kind = KIND_NONE;
        if (n)
        begin
            restart_line();
            prev_kind = KIND_NONE;
            return 1'b1;
        end
        if (mode == LM_START)
        begin
            if (c > CH_ASCII_MAX || c == CH_NL)
            begin
                held_kind = KIND_NONE;
                mode      = LM_DECIDED;
            end
            else if (c == CH_SPACE || c == CH_TAB)
            begin
                held_kind = prev_kind;
                mode      = LM_DECIDED;
            end
            else
            begin
                mode = LM_HEADER;
                scan_byte(c);
            end
        end
        else if (mode == LM_HEADER)
        begin
            scan_byte(c);
        end
        if (!e)
            return 1'b0;
        kind      = (mode == LM_HEADER) ? decide_kind() : held_kind;
        prev_kind = kind;
        restart_line();
        return 1'b1;
    endfunction

    task automatic send_item(input logic [7:0] c, input logic e, input logic n,
                             input int forced);
        logic [KIND_W-1:0] kind;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        ch         <= c;
        line_end   <= e;
        no_line    <= n;
        do
            @(posedge clk);
        while (item_stall);
        sent_count++;
        if (classify_byte(c, e, n, kind))
            pending_kinds.push_back(forced >= 0 ? KIND_W'(forced) : kind);
    endtask

    // Transfer line_bytes in order, line_end on the last unless left open
    task automatic send_line(input bit open_end, input int forced);
        int last;
        last = line_bytes.size() - 1;
        for (int k = 0; k <= last; k++)
            send_item(line_bytes[k], (k == last) && !open_end, 1'b0,
                      (k == last) ? forced : KIND_BY_TABLE);
    endtask

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            line_bytes.push_back(s[k]);
    endfunction

    function automatic void add_value(input int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                line_bytes.push_back(8'($urandom_range(0, 255)));
            else
                line_bytes.push_back(8'($urandom_range(32, 126)));
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: check transfers, stall in bursts or for a long hold
    initial
    begin
        int  hold_left;
        int  burst_left;
        logic nxt;
        logic [KIND_W-1:0] want;
        hold_left  = 0;
        burst_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (pending_kinds.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, header_kind);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_kinds.pop_front();
                    if (header_kind !== want)
                    begin
                        $display("%0t: header_kind mismatch, expected %0d, got %0d",
                                 $time, want, header_kind);
                        mismatch_count++;
                    end
                end
            end
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                nxt = 1'b1;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(1, 3) - 1;
                nxt = 1'b1;
            end
            else
            begin
                nxt = 1'b0;
            end
            result_stall <= nxt;
        end
    end

    initial
    begin
        int  pick;
        int  idx;
        int  guard;
        bit  hold_done;
        bit  pause_done;
        logic [7:0] b;

        rst_n          = 1'b0;
        item_valid     = 1'b0;
        ch             = '0;
        line_end       = 1'b0;
        no_line        = 1'b0;
        result_stall   = 1'b0;
        mismatch_count = 0;
        sent_count     = 0;
        idle_en        = 1'b1;
        hold_off_go    = 1'b0;
        hold_done      = 1'b0;
        pause_done     = 1'b0;
        restart_line();
        prev_kind = KIND_NONE;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_cases[r])
        begin
            if (dir_cases[r].end_of_input)
            begin
                send_item(8'h00, 1'b0, 1'b1, dir_cases[r].kind);
            end
            else
            begin
                line_bytes.delete();
                if (dir_cases[r].has_lead)
                    line_bytes.push_back(dir_cases[r].lead);
                add_text(dir_cases[r].text);
                send_line(dir_cases[r].open_end, dir_cases[r].kind);
            end
        end

        sent_count = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            if (sent_count >= RANDOM_ITEMS - CALM_ITEMS)
                idle_en = 1'b0;
            if (!hold_done && sent_count >= HOLD_AT_ITEM)
            begin
                hold_done   = 1'b1;
                hold_off_go = 1'b1;
            end
            if (!pause_done && sent_count >= PAUSE_AT_ITEM)
            begin
                pause_done = 1'b1;
                item_valid <= 1'b0;
                wait (pending_kinds.size() == 0);
                repeat (TAIL_CYCLES) @(posedge clk);
            end

            line_bytes.delete();
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // known name, random letter case, sometimes damaged
                idx = $urandom_range(0, TABLE_LEN - 1);
                for (int k = 0; k < hdr_name[idx].len(); k++)
                begin
                    b = hdr_name[idx][k];
                    if (b >= "A" && b <= "z" && fold_case(b) != b && $urandom_range(0, 1))
                        b = fold_case(b);
                    else if (b >= "a" && b <= "z" && $urandom_range(0, 1))
                        b = b - 8'h20;
                    line_bytes.push_back(b);
                end
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    void'(line_bytes.pop_back());
                end
                else if (pick == 1)
                begin
                    void'(line_bytes.pop_back());
                    add_text(" :");
                end
                else if (pick == 2)
                begin
                    line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
                        8'($urandom_range(32, 126));
                end
                add_value($urandom_range(0, 12));
            end
            else if (pick < 65)
            begin
                line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                add_value($urandom_range(0, 8));
            end
            else if (pick < 70)
            begin
                line_bytes.push_back(CH_NL);
            end
            else if (pick < 75)
            begin
                line_bytes.push_back(8'($urandom_range(128, 255)));
                add_value($urandom_range(0, 6));
            end
            else if (pick < 80)
            begin
                // drop a partly read line with an end-of-input transfer
                add_value($urandom_range(0, 5));
                if (line_bytes.size() > 0)
                    send_line(1'b1, KIND_BY_TABLE);
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                          KIND_BY_TABLE);
                line_bytes.delete();
            end
            else if (pick < 90)
            begin
                add_text("X-");
                repeat ($urandom_range(1, 6))
                    line_bytes.push_back(8'($urandom_range("a", "z")));
                line_bytes.push_back(CH_COLON);
                add_value($urandom_range(0, 8));
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if (line_bytes.size() > 0)
                send_line(1'b0, KIND_BY_TABLE);
        end
        item_valid <= 1'b0;

        guard = 0;
        while (pending_kinds.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_kinds.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_kinds.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/nhlc_pkg.sv
hw/rtl/nhlc_cell.sv
hw/rtl/news_header_line_classifier_unit.sv
bench/tb.sv
